// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, muted while reset is held
`define PIDS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// plain condition that must hold at every rising edge out of reset
`define PIDS_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`endif

// ----- hw/rtl/pids_pkg.sv -----
// types and constants for the positional insert/delete stack
package pids_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam int S_TDATA_W = ((POS_W + WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_W + COUNT_W + WORD_W + 7) / 8) * 8;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_DELETE = 2'd2
    } status_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic [IDX_W-1:0] slot;
        word_t            word;
    } cell_cmd_t;

endpackage

// ----- hw/rtl/positional_insert_delete_stack_unit.sv -----
// top level of the positional insert/delete stack
// A bounded stack of DEPTH signed 32-bit words held in a chain of cells, cell 0
// being the top of the stack. An input beat is an insert (word placed at a
// position counted from the top, a position at or past the count lands at the
// bottom) or a delete (word at a position counted from the bottom is removed
// and returned). Every beat yields exactly one result beat with status, removed
// word, element count and top word. All cells compare their own index with the
// target slot and shift toward or away from the top in the same clock, so one
// beat is taken per cycle; the result sits in an output register and the next
// beat is taken as long as that register is empty or being drained. A full
// insert or a bad delete leaves the stack unchanged. Cell contents are not
// cleared at reset; only the count and the output valid flag are.
`include "assert_macros.svh"

module positional_insert_delete_stack_unit
    import pids_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position [4:0], value [36:5], zero pad
    input  logic [0:0]           s_tuser,   // op [0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // removed_value [31:0], element_count [36:32],
                                            // top_value [68:37], zero pad
    output logic [1:0]           m_tuser    // status [1:0]
);

    // input beat fields
    logic [POS_W-1:0] in_pos;
    word_t            in_value;
    op_t              in_op;
    logic             s_accept;

    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W+WORD_W-1:POS_W];
    assign in_op    = op_t'(s_tuser[0]);
    assign s_accept = s_tvalid && s_tready;

    // stack fill count
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // output register
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [1:0]           m_tuser_reg;
    logic [1:0]           m_tuser_next;

    // slot decode, done in a width that holds both position and count
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             pos_past_cnt;
    logic             is_full;
    logic             is_empty;
    logic             ins_ok;
    logic             del_ok;
    logic [IDX_W-1:0] ins_slot;
    logic [IDX_W-1:0] del_slot;
    logic [CMP_W-1:0] del_dist;

    cell_cmd_t cmd;
    word_t     cell_q [DEPTH];
    word_t     cell_d [DEPTH];
    word_t     removed;
    word_t     top_next;
    status_t   status;

    assign pos_ext      = CMP_W'(in_pos);
    assign cnt_ext      = CMP_W'(count_reg);
    assign pos_past_cnt = (pos_ext >= cnt_ext);
    assign is_full      = (count_reg == DEPTH_CNT);
    assign is_empty     = (count_reg == '0);

    // insert: distance from top, clamped to the bottom
    assign ins_slot = pos_past_cnt ? count_reg[IDX_W-1:0] : pos_ext[IDX_W-1:0];
    // delete: position from bottom turned into distance from top
    assign del_dist = cnt_ext - CMP_W'(1) - pos_ext;
    assign del_slot = del_dist[IDX_W-1:0];

    assign ins_ok = s_accept && (in_op == OP_INSERT) && !is_full;
    assign del_ok = s_accept && (in_op == OP_DELETE) && !is_empty && !pos_past_cnt;

    always_comb begin
        cmd.ins_en = ins_ok;
        cmd.del_en = del_ok;
        cmd.slot   = (in_op == OP_INSERT) ? ins_slot : del_slot;
        cmd.word   = in_value;
    end

    // chain of cells, each takes from its upper or lower neighbor
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        word_t prev_w;
        word_t next_w;
        if (k == 0) begin : g_first
            assign prev_w = '0;
        end else begin : g_prev
            assign prev_w = cell_q[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign next_w = '0;
        end else begin : g_next
            assign next_w = cell_q[k+1];
        end
        pids_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .cell_idx  (IDX_W'(k)),
            .prev_data (prev_w),
            .next_data (next_w),
            .data      (cell_q[k]),
            .data_next (cell_d[k])
        );
    end

    // word leaving the stack on a good delete
    assign removed = del_ok ? cell_q[del_slot] : '0;

    always_comb begin
        count_next = count_reg;
        if (ins_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (del_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign top_next = (count_next == '0) ? '0 : cell_d[0];

    always_comb begin
        status = ST_OK;
        if (in_op == OP_INSERT) begin
            if (is_full) begin
                status = ST_FULL;
            end
        end else if (!del_ok) begin
            status = ST_BAD_DELETE;
        end
    end

    // output register, refilled whenever a beat is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            m_valid_next = 1'b1;
            m_tdata_next = '0;
            m_tdata_next[WORD_W-1:0]                        = removed;
            m_tdata_next[WORD_W+COUNT_W-1:WORD_W]           = COUNT_W'(count_next);
            m_tdata_next[2*WORD_W+COUNT_W-1:WORD_W+COUNT_W] = top_next;
            m_tuser_next = status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // count never runs past the number of cells
    `PIDS_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= DEPTH_CNT, "count past depth")
    // an insert into a full stack reports full and keeps the count
    `PIDS_ASSERT(a_full_insert, aclk, aresetn, (s_accept && in_op == OP_INSERT && is_full) |=> (m_tuser == ST_FULL && count_reg == DEPTH_CNT), "full insert not flagged")
    // count moves only when a beat is taken
    `PIDS_ASSERT(a_count_hold, aclk, aresetn, !s_accept |=> $stable(count_reg), "count moved without a beat")
    // a stalled result blocks the input side
    `PIDS_ASSERT(a_stall_blocks, aclk, aresetn, (m_tvalid && !m_tready) |-> !s_tready, "input taken over a stalled result")

endmodule

// ----- hw/rtl/pids_cell.sv -----
// one storage cell of the stack chain, index 0 holds the top word
module pids_cell
    import pids_pkg::*;
(
    input  logic             aclk,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] cell_idx,
    input  word_t            prev_data,
    input  word_t            next_data,
    output word_t            data,
    output word_t            data_next
);

    word_t data_reg;

    always_comb begin
        data_next = data_reg;
        if (cmd.ins_en) begin
            if (cell_idx == cmd.slot) begin
                data_next = cmd.word;
            end else if (cell_idx > cmd.slot) begin
                data_next = prev_data;
            end
        end else if (cmd.del_en && (cell_idx >= cmd.slot)) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- tb/tb_positional_insert_delete_stack_unit.sv -----
// self-checking testbench for the positional insert/delete stack unit
module tb_positional_insert_delete_stack_unit;
    import pids_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one result beat, split into its fields
    typedef struct packed {
        status_t              st;
        word_t                removed;
        logic [COUNT_W-1:0]   count;
        word_t                top;
    } stack_result_t;

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        op_t                  op;
        logic [POS_W-1:0]     pos;
        word_t                value;
        logic                 typed;
        stack_result_t        res;
    } dir_row_t;

    localparam stack_result_t UNTYPED = '{ST_OK, 32'h0, 5'd0, 32'h0};
    localparam int NUM_DIRECTED = 28;
    localparam int RAND_ITEMS   = 1222;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 21;

    // directed walk: empty stack, extremes of value and position, bottom clamp,
    // ignored value on delete, fill to full, insert into full, bad deletes
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // delete from empty stack
        '{OP_DELETE, 5'd0,  32'h0000_0000, 1'b1, '{ST_BAD_DELETE, 32'h0, 5'd0, 32'h0}},
        // plain push of the largest word
        '{OP_INSERT, 5'd0,  32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'h0, 5'd1, 32'h7FFF_FFFF}},
        // position past the count lands at the bottom, top unchanged
        '{OP_INSERT, 5'd16, 32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 5'd2, 32'h7FFF_FFFF}},
        '{OP_INSERT, 5'd1,  32'hFFFF_FFFF, 1'b0, UNTYPED},
        // delete at the largest position
        '{OP_DELETE, 5'd16, 32'h0000_0000, 1'b1, '{ST_BAD_DELETE, 32'h0, 5'd3, 32'h7FFF_FFFF}},
        // delete exactly at the count
        '{OP_DELETE, 5'd3,  32'h0000_0000, 1'b0, UNTYPED},
        // value field must be ignored on delete
        '{OP_DELETE, 5'd0,  32'h1234_5678, 1'b0, UNTYPED},
        '{OP_DELETE, 5'd1,  32'hFFFF_FFFF, 1'b0, UNTYPED},
        '{OP_DELETE, 5'd0,  32'h8000_0000, 1'b0, UNTYPED},
        // sixteen inserts at mixed positions fill the stack from empty
        '{OP_INSERT, 5'd0,  32'h0000_0000, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd16, 32'hFFFF_FFFF, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd2,  32'h8000_0000, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd1,  32'h7FFF_FFFF, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd5,  32'hA5A5_A5A5, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd0,  32'h5A5A_5A5A, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd3,  32'hDEAD_BEEF, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd15, 32'h0000_0010, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd7,  32'h0F0F_0F0F, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd0,  32'hF0F0_F0F0, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd9,  32'h1111_1111, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd4,  32'h2222_2222, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd12, 32'h3333_3333, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd0,  32'h4444_4444, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd6,  32'h5555_5555, 1'b0, UNTYPED},
        '{OP_INSERT, 5'd0,  32'h0000_0001, 1'b1, '{ST_OK, 32'h0, 5'd16, 32'h0000_0001}},
        // insert into a full stack leaves it untouched
        '{OP_INSERT, 5'd3,  32'h7777_7777, 1'b1, '{ST_FULL, 32'h0, 5'd16, 32'h0000_0001}},
        // remove the top through a position from the bottom, then miss by one
        '{OP_DELETE, 5'd15, 32'h0000_0000, 1'b0, UNTYPED},
        '{OP_DELETE, 5'd15, 32'h0000_0000, 1'b0, UNTYPED}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // position [4:0], value [36:5], zero pad
    logic [0:0]           s_tuser;   // op [0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // removed_value [31:0], element_count [36:32],
                                     // top_value [68:37], zero pad
    logic [1:0]           m_tuser;   // status [1:0]

    // typed expectation travels with the beat it belongs to
    logic                 beat_typed;
    stack_result_t        beat_typed_res;

    // shadow copy of the stack, index 0 is the bottom
    word_t                stk_cells [DEPTH];
    int                   stk_count = 0;

    stack_result_t        pending_results [$];
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    bit                   gaps_on = 1'b1;

    positional_insert_delete_stack_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // applies one operation to the shadow stack and returns the result beat
    function automatic stack_result_t apply_stack_op(input op_t op,
                                                     input logic [POS_W-1:0] pos,
                                                     input word_t value);
        stack_result_t res;
        int n;
        int slot;
        int i;
        res = UNTYPED;
        n = stk_count;
        if (op == OP_INSERT) begin
            if (n >= DEPTH) begin
                res.st = ST_FULL;
            end else begin
                // position counts from the top; past the count means bottom
                slot = (int'(pos) >= n) ? 0 : n - int'(pos);
                for (i = n; i > slot; i--)
                    stk_cells[i] = stk_cells[i-1];
                stk_cells[slot] = value;
                stk_count = n + 1;
            end
        end else begin
            if (n == 0 || int'(pos) >= n) begin
                res.st = ST_BAD_DELETE;
            end else begin
                // position counts from the bottom; words above slide down
                res.removed = stk_cells[int'(pos)];
                for (i = int'(pos); i + 1 < n; i++)
                    stk_cells[i] = stk_cells[i+1];
                stk_count = n - 1;
            end
        end
        res.count = stk_count[COUNT_W-1:0];
        res.top = (stk_count == 0) ? '0 : stk_cells[stk_count-1];
        return res;
    endfunction

    // presents one beat after a random idle gap and returns once it is taken
    task automatic send_beat(input op_t op, input logic [POS_W-1:0] pos, input word_t value,
                             input logic typed, input stack_result_t typed_res);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid       <= 1'b1;
        s_tuser        <= op;
        s_tdata        <= {{(S_TDATA_W-POS_W-WORD_W){1'b0}}, value, pos};
        beat_typed     <= typed;
        beat_typed_res <= typed_res;
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side back-pressure, off during the quiet stretch
    always @(posedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // both handshakes are seen in one block so an accepted input beat is always
    // queued before a result beat taken at the same edge is checked
    always @(posedge aclk) begin
        stack_result_t want;
        stack_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = apply_stack_op(op_t'(s_tuser[0]), s_tdata[POS_W-1:0],
                                      s_tdata[POS_W +: WORD_W]);
                if (beat_typed)
                    want = beat_typed_res;
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.st      = status_t'(m_tuser);
                got.removed = m_tdata[WORD_W-1:0];
                got.count   = m_tdata[WORD_W +: COUNT_W];
                got.top     = m_tdata[WORD_W+COUNT_W +: WORD_W];
                if (pending_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("result beat with nothing expected: %s %0d %s %h %s %0d %s %h",
                                 "status", got.st, "removed", got.removed,
                                 "count", got.count, "top", got.top);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.st !== want.st || got.removed !== want.removed ||
                        got.count !== want.count || got.top !== want.top) begin
                        if (mismatch_count < 10) begin
                            $write("mismatch: want status %0d removed %h count %0d top %h",
                                   want.st, want.removed, want.count, want.top);
                            $display(", got status %0d removed %h count %0d top %h",
                                     got.st, got.removed, got.count, got.top);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL positional_insert_delete_stack_unit");
            $finish;
        end
    end

    initial begin
        int ins_bias;
        int pos_lim;
        op_t op;
        logic [POS_W-1:0] pos;
        word_t value;
        word_t corner_words [4];

        corner_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        ins_bias = 50;

        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= '0;
        beat_typed     <= 1'b0;
        beat_typed_res <= UNTYPED;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int r = 0; r < NUM_DIRECTED; r++)
            send_beat(DIRECTED[r].op, DIRECTED[r].pos, DIRECTED[r].value,
                      DIRECTED[r].typed, DIRECTED[r].res);

        // random part: insert weight is redrawn every hundred beats so the stack
        // keeps sweeping between empty and full
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(2))
                    0: ins_bias = 15;
                    1: ins_bias = 50;
                    default: ins_bias = 85;
                endcase
            end
            // quiet stretch with no gaps on either side
            gaps_on = !(n >= 500 && n < 750);
            op = ($urandom_range(99) < ins_bias) ? OP_INSERT : OP_DELETE;
            // mostly positions near the live range, sometimes anything legal
            pos_lim = (stk_count + 1 > DEPTH) ? DEPTH : stk_count + 1;
            if ($urandom_range(9) < 7)
                pos = POS_W'($urandom_range(pos_lim, 0));
            else
                pos = POS_W'($urandom_range(DEPTH, 0));
            if ($urandom_range(7) == 0)
                value = corner_words[$urandom_range(3)];
            else
                value = $urandom;
            send_beat(op, pos, value, 1'b0, UNTYPED);
        end
        s_tvalid <= 1'b0;
        gaps_on = 1'b1;

        // drain, then keep watching for stray result beats
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASS positional_insert_delete_stack_unit");
        else
            $display("FAIL positional_insert_delete_stack_unit");
        $finish;
    end

endmodule
